// ===== hdl/deadline_timer_event_queue_macros.svh =====
// assertion macros for the deadline timer event queue
`ifndef DEADLINE_TIMER_EVENT_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_EVENT_QUEUE_MACROS_SVH

// same-cycle implication
`define DTEQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dteq: assertion failed");

// next-cycle implication
`define DTEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dteq: assertion failed");

`endif

// ===== hdl/dteq_pkg.sv =====
// shared types and constants of the deadline timer event queue
package dteq_pkg;

   localparam int CMD_BITS        = 3;
   localparam int TIME_BITS       = 48;
   localparam int HANDLE_W        = 16;
   localparam int STATUS_BITS     = 3;
   localparam int TPS_BITS        = 20;
   localparam int TPS_CNT_W       = $clog2(TPS_BITS);
   localparam logic [TPS_BITS-1:0] TPS_RESET = 20'd1000;
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_HANDLE_BITS = 16;
   localparam int RESULT_LIMIT    = 16;
   localparam int FIRE_W          = $clog2(RESULT_LIMIT + 1);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK       = 3'd0,
      CMD_ADD_AT     = 3'd1,
      CMD_ADD_AFTER  = 3'd2,
      CMD_CANCEL     = 3'd3,
      CMD_CANCEL_ALL = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_FIRED     = 3'd0,
      STATUS_ADDED     = 3'd1,
      STATUS_DUPLICATE = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_CANCELLED = 3'd4,
      STATUS_NOT_FOUND = 3'd5,
      STATUS_CLEARED   = 3'd6,
      STATUS_NONE_DUE  = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELAY,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_REM_RD,
      ST_REM_WR,
      ST_INS_RD,
      ST_INS_WR,
      ST_TICK_RD,
      ST_TICK_CMP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                 done;
      logic [TIME_BITS-1:0] deadline;
   } delay_status_type;

endpackage

// ===== hdl/dteq_if.sv =====
// request and response channel interfaces
interface dteq_req_if import dteq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_BITS-1:0]  cmd;
   logic [TIME_BITS-1:0] now_time;
   logic [TIME_BITS-1:0] time_amount;
   logic [HANDLE_W-1:0]  event_handle;

   modport source (output valid, cmd, now_time, time_amount, event_handle, input ready);
   modport sink (input valid, cmd, now_time, time_amount, event_handle, output ready);
endinterface

interface dteq_rsp_if import dteq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [HANDLE_W-1:0]    result_handle;
   logic [TIME_BITS-1:0]   result_deadline;
   logic                   last_result;

   modport source (output valid, status, result_handle, result_deadline, last_result,
                   input ready);
   modport sink (input valid, status, result_handle, result_deadline, last_result,
                 output ready);
endinterface

// ===== hdl/deadline_timer_event_queue.sv =====
// deadline timer event queue: sorted event table with sequencer and output register
//
//   channel   dir   transfer when        carries
//   req_ch    in    valid && ready       cmd, now_time, time_amount, event_handle
//   rsp_ch    out   valid && ready       status, result_handle, result_deadline, last_result
//   csr_*     in    csr_write_enable     ticks_per_second
//
// one command at a time; req_ch.ready is high only while the sequencer is idle.
// add and cancel scan the whole table, then move entries one at a time through the
// table memory; add after delay first runs the bit-serial multiplier. a tick fires
// the due events from the head of the table, at most RESULT_LIMIT of them per tick.
// reset empties the table and loads ticks_per_second with 1000; no clearing pass.
// a full output register stalls the sequencer; the next command is taken while
// the final result still waits.
`include "deadline_timer_event_queue_macros.svh"

module deadline_timer_event_queue import dteq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
   input  logic                clock,
   input  logic                reset,
   dteq_req_if.sink            req_ch,
   dteq_rsp_if.source          rsp_ch,
   input  logic                csr_write_enable,
   input  logic [TPS_BITS-1:0] csr_write_data
);

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam int IdxW = $clog2(QUEUE_DEPTH);

   // table memory
   logic [TIME_BITS-1:0]   mem_dl [QUEUE_DEPTH];
   logic [HANDLE_BITS-1:0] mem_h  [QUEUE_DEPTH];
   logic                   wr_en, rd_en;
   logic [IdxW-1:0]        wr_addr, rd_addr;
   logic [TIME_BITS-1:0]   wr_dl;
   logic [HANDLE_BITS-1:0] wr_h;
   logic [TIME_BITS-1:0]   rd_dl_ff;
   logic [HANDLE_BITS-1:0] rd_h_ff;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [TPS_BITS-1:0]    tps_ff, tps_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [TIME_BITS-1:0]   dl_ff, dl_in;
   logic [HANDLE_BITS-1:0] key_ff, key_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic [IdxW-1:0]        head_ff, head_in;
   logic [CntW-1:0]        scan_ff, scan_in;
   logic [CntW-1:0]        pos_ff, pos_in;
   logic                   found_ff, found_in;
   logic [CntW-1:0]        found_idx_ff, found_idx_in;
   logic [TIME_BITS-1:0]   found_dl_ff, found_dl_in;
   logic [FIRE_W-1:0]      fired_ff, fired_in;
   logic                   pend_ff, pend_in;
   status_type             res_status_ff, res_status_in;
   logic [HANDLE_BITS-1:0] res_handle_ff, res_handle_in;
   logic [TIME_BITS-1:0]   res_dl_ff, res_dl_in;
   logic                   out_valid_ff, out_valid_in;
   status_type             out_status_ff, out_status_in;
   logic [HANDLE_W-1:0]    out_handle_ff, out_handle_in;
   logic [TIME_BITS-1:0]   out_dl_ff, out_dl_in;
   logic                   out_last_ff, out_last_in;

   logic                   load, load_last, slot_free, fire_pop;
   logic [31:0]            handle_wide;
   logic [31:0]            res_handle_wide;
   logic                   dly_start;
   delay_status_type       dly_status;

   // logical table position to memory address, the table is a ring from head
   function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] head,
                                            input logic [CntW-1:0] lidx);
      logic [CntW:0] s;
      s = (CntW+1)'(head) + (CntW+1)'(lidx);
      if (s >= (CntW+1)'(QUEUE_DEPTH)) begin
         s = s - (CntW+1)'(QUEUE_DEPTH);
      end
      return s[IdxW-1:0];
   endfunction

   dteq_delay_unit u_delay (
      .clock     (clock),
      .reset     (reset),
      .start     (dly_start),
      .base_time (req_ch.now_time),
      .seconds   (req_ch.time_amount),
      .rate      (tps_ff),
      .status    (dly_status)
   );

   assign handle_wide     = 32'(req_ch.event_handle);
   assign res_handle_wide = 32'(res_handle_ff);
   assign slot_free       = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      tps_in        = csr_write_enable ? csr_write_data : tps_ff;
      now_in        = now_ff;
      dl_in         = dl_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_dl_in   = found_dl_ff;
      fired_in      = fired_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_dl_in     = res_dl_ff;
      load          = 1'b0;
      load_last     = 1'b0;
      fire_pop      = 1'b0;
      dly_start     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = phys(head_ff, scan_ff);
      wr_dl         = rd_dl_ff;
      wr_h          = rd_h_ff;
      rd_en         = 1'b0;
      rd_addr       = phys(head_ff, scan_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = cmd_type'(req_ch.cmd);
               now_in   = req_ch.now_time;
               dl_in    = req_ch.time_amount;
               key_in   = handle_wide[HANDLE_BITS-1:0];
               scan_in  = '0;
               pos_in   = '0;
               found_in = 1'b0;
               fired_in = '0;
               pend_in  = 1'b0;
               case (cmd_type'(req_ch.cmd))
                  CMD_TICK:      state_in = ST_TICK_RD;
                  CMD_ADD_AT,
                  CMD_CANCEL:    state_in = ST_SCAN_RD;
                  CMD_ADD_AFTER: begin
                     dly_start = 1'b1;
                     state_in  = ST_DELAY;
                  end
                  CMD_CANCEL_ALL: begin
                     count_in      = '0;
                     res_status_in = STATUS_CLEARED;
                     res_handle_in = '0;
                     res_dl_in     = '0;
                     state_in      = ST_EMIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_DELAY: begin
            if (dly_status.done) begin
               dl_in    = dly_status.deadline;
               state_in = ST_SCAN_RD;
            end
         end

         ST_SCAN_RD: begin
            if (scan_ff == count_ff) begin
               res_handle_in = key_ff;
               if (cmd_ff == CMD_CANCEL) begin
                  if (found_ff) begin
                     res_status_in = STATUS_CANCELLED;
                     res_dl_in     = found_dl_ff;
                     scan_in       = found_idx_ff;
                     state_in      = ST_REM_RD;
                  end else begin
                     res_status_in = STATUS_NOT_FOUND;
                     res_dl_in     = '0;
                     state_in      = ST_EMIT;
                  end
               end else begin
                  res_dl_in = dl_ff;
                  if (found_ff) begin
                     res_status_in = STATUS_DUPLICATE;
                     state_in      = ST_EMIT;
                  end else if (count_ff == CntW'(QUEUE_DEPTH)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_EMIT;
                  end else begin
                     res_status_in = STATUS_ADDED;
                     state_in      = ST_INS_RD;
                  end
               end
            end else begin
               rd_en    = 1'b1;
               state_in = ST_SCAN_CMP;
            end
         end

         ST_SCAN_CMP: begin
            if (rd_h_ff == key_ff && !found_ff) begin
               found_in     = 1'b1;
               found_idx_in = scan_ff;
               found_dl_in  = rd_dl_ff;
            end
            // table is sorted, so the insert point follows the last entry due no later
            if (rd_dl_ff <= dl_ff) begin
               pos_in = scan_ff + 1'b1;
            end
            scan_in  = scan_ff + 1'b1;
            state_in = ST_SCAN_RD;
         end

         ST_REM_RD: begin
            if (scan_ff + 1'b1 == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, scan_ff + 1'b1);
               state_in = ST_REM_WR;
            end
         end

         ST_REM_WR: begin
            wr_en    = 1'b1;
            scan_in  = scan_ff + 1'b1;
            state_in = ST_REM_RD;
         end

         ST_INS_RD: begin
            if (scan_ff == pos_ff) begin
               wr_en    = 1'b1;
               wr_dl    = dl_ff;
               wr_h     = key_ff;
               count_in = count_ff + 1'b1;
               state_in = ST_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, scan_ff - 1'b1);
               state_in = ST_INS_WR;
            end
         end

         ST_INS_WR: begin
            wr_en    = 1'b1;
            scan_in  = scan_ff - 1'b1;
            state_in = ST_INS_RD;
         end

         ST_TICK_RD: begin
            if (count_ff != '0 && fired_ff != FIRE_W'(RESULT_LIMIT)) begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = ST_TICK_CMP;
            end else begin
               if (!pend_ff) begin
                  res_status_in = STATUS_NONE_DUE;
                  res_handle_in = '0;
                  res_dl_in     = '0;
               end
               state_in = ST_EMIT;
            end
         end

         ST_TICK_CMP: begin
            if (rd_dl_ff <= now_ff) begin
               // the held event goes out only once another one is known to follow
               if (!pend_ff || slot_free) begin
                  load          = pend_ff;
                  fire_pop      = 1'b1;
                  res_status_in = STATUS_FIRED;
                  res_handle_in = rd_h_ff;
                  res_dl_in     = rd_dl_ff;
                  pend_in       = 1'b1;
                  head_in       = (head_ff == IdxW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  count_in      = count_ff - 1'b1;
                  fired_in      = fired_ff + 1'b1;
                  state_in      = ST_TICK_RD;
               end
            end else begin
               if (!pend_ff) begin
                  res_status_in = STATUS_NONE_DUE;
                  res_handle_in = '0;
                  res_dl_in     = '0;
               end
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (slot_free) begin
               load      = 1'b1;
               load_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_status_in = out_status_ff;
      out_handle_in = out_handle_ff;
      out_dl_in     = out_dl_ff;
      out_last_in   = out_last_ff;
      if (load) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_handle_in = res_handle_wide[HANDLE_W-1:0];
         out_dl_in     = res_dl_ff;
         out_last_in   = load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tps_ff       <= TPS_RESET;
         count_ff     <= '0;
         head_ff      <= '0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         fired_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         tps_ff       <= tps_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         fired_ff     <= fired_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      dl_ff         <= dl_in;
      key_ff        <= key_in;
      scan_ff       <= scan_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_dl_ff   <= found_dl_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_dl_ff     <= res_dl_in;
      out_status_ff <= out_status_in;
      out_handle_ff <= out_handle_in;
      out_dl_ff     <= out_dl_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_dl[wr_addr] <= wr_dl;
         mem_h[wr_addr]  <= wr_h;
      end
      if (rd_en) begin
         rd_dl_ff <= mem_dl[rd_addr];
         rd_h_ff  <= mem_h[rd_addr];
      end
   end

   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.status          = out_status_ff;
   assign rsp_ch.result_handle   = out_handle_ff;
   assign rsp_ch.result_deadline = out_dl_ff;
   assign rsp_ch.last_result     = out_last_ff;

   `DTEQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(QUEUE_DEPTH))
   `DTEQ_ASSERT_IMPL(a_head_bound, clock, reset, 1'b1, head_ff < IdxW'(QUEUE_DEPTH - 1) || head_ff == IdxW'(QUEUE_DEPTH - 1))
   `DTEQ_ASSERT_IMPL(a_fired_is_due, clock, reset, load && res_status_ff == STATUS_FIRED, res_dl_ff <= now_ff)
   `DTEQ_ASSERT_IMPL(a_full_only_when_full, clock, reset, load && res_status_ff == STATUS_FULL, count_ff == CntW'(QUEUE_DEPTH))
   `DTEQ_ASSERT_NEXT(a_fire_pops, clock, reset, fire_pop, count_ff == $past(count_ff) - 1'b1)

endmodule

// ===== hdl/dteq_delay_unit.sv =====
// bit-serial saturating deadline unit: base + seconds * rate
module dteq_delay_unit import dteq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS-1:0] base_time,
   input  logic [TIME_BITS-1:0] seconds,
   input  logic [TPS_BITS-1:0]  rate,
   output delay_status_type     status
);

   logic                 busy_ff, busy_in;
   logic                 final_ff, final_in;
   logic                 done_ff, done_in;
   logic [TPS_CNT_W-1:0] bit_ff, bit_in;
   logic [TPS_BITS-1:0]  rate_ff, rate_in;
   logic [TIME_BITS-1:0] secs_ff, secs_in;
   logic [TIME_BITS-1:0] base_ff, base_in;
   logic [TIME_BITS-1:0] acc_ff, acc_in;
   logic                 ovf_ff, ovf_in;
   logic [TIME_BITS-1:0] dl_ff, dl_in;
   logic [TIME_BITS+1:0] step_sum;
   logic [TIME_BITS:0]   final_sum;

   assign step_sum  = {1'b0, acc_ff, 1'b0}
                    + (rate_ff[TPS_BITS-1] ? (TIME_BITS+2)'(secs_ff) : '0);
   assign final_sum = (TIME_BITS+1)'(base_ff) + (TIME_BITS+1)'(acc_ff);

   always_comb begin
      busy_in  = busy_ff;
      final_in = 1'b0;
      done_in  = 1'b0;
      bit_in   = bit_ff;
      rate_in  = rate_ff;
      secs_in  = secs_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      dl_in    = dl_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = TPS_CNT_W'(TPS_BITS - 1);
         rate_in = rate;
         secs_in = seconds;
         base_in = base_time;
         acc_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         // msb first: shift the product left and add seconds when the next rate bit is set
         acc_in  = step_sum[TIME_BITS-1:0];
         ovf_in  = ovf_ff | (|step_sum[TIME_BITS+1:TIME_BITS]);
         rate_in = {rate_ff[TPS_BITS-2:0], 1'b0};
         bit_in  = bit_ff - 1'b1;
         if (bit_ff == '0) begin
            busy_in  = 1'b0;
            final_in = 1'b1;
         end
      end else if (final_ff) begin
         done_in = 1'b1;
         dl_in   = (ovf_ff || final_sum[TIME_BITS]) ? '1 : final_sum[TIME_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         final_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         final_ff <= final_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff  <= bit_in;
      rate_ff <= rate_in;
      secs_ff <= secs_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      ovf_ff  <= ovf_in;
      dl_ff   <= dl_in;
   end

   assign status.done     = done_ff;
   assign status.deadline = dl_ff;

endmodule
